// ----- rtl/core/hourly_relay_on_time_tracker_unit_macros.svh -----
// Assertion helpers for the relay on-time tracker
`ifndef HOURLY_RELAY_ON_TIME_TRACKER_UNIT_MACROS_SVH
`define HOURLY_RELAY_ON_TIME_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define HROT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define HROT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/hrot_pkg.sv -----
package hrot_pkg;

  localparam int BUCKET_COUNT = 24;
  localparam int ADDR_W       = $clog2(BUCKET_COUNT);
  localparam int HOUR_W       = 5;
  localparam int BUCKET_W     = 12;
  localparam int TIME_W       = 32;
  localparam int INTO_W       = 12;
  localparam int SUM_W        = 17;
  localparam int WIN_W        = 5;

  localparam logic [BUCKET_W-1:0] HOUR_CAP   = 12'd3600;
  localparam logic [TIME_W-1:0]   GAP_LIMIT  = 32'd120;
  localparam logic [HOUR_W-1:0]   NO_HOUR    = 5'd31;
  localparam logic [WIN_W-1:0]    MAX_WINDOW = 5'd24;
  localparam logic [HOUR_W-1:0]   LAST_HOUR  = HOUR_W'(BUCKET_COUNT - 1);
  localparam logic [ADDR_W-1:0]   LAST_ADDR  = ADDR_W'(BUCKET_COUNT - 1);

  // Shared unit operations
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } hrot_alu_op_t;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] now_seconds;
    logic [HOUR_W-1:0] hour_of_day;
    logic [INTO_W-1:0] seconds_into_hour;
    logic              relay_on;
  } hrot_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] window_on_seconds;
    logic             tracked_on;
  } hrot_out_t;

  // Bucket store write port
  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [BUCKET_W-1:0] data;
  } hrot_wr_t;

endpackage

// ----- rtl/core/hrot_alu.sv -----
module hrot_alu (
  input  hrot_pkg::hrot_alu_op_t      op,
  input  logic [hrot_pkg::TIME_W-1:0] a,
  input  logic [hrot_pkg::TIME_W-1:0] b,
  output logic [hrot_pkg::TIME_W:0]   res
);
  import hrot_pkg::*;

  // One 32-bit adder/subtractor; top bit is the carry out of an add
  always_comb begin
    unique case (op)
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      ALU_SUB: res = {1'b0, a} - {1'b0, b};
      default: res = '0;
    endcase
  end

endmodule

// ----- rtl/core/hrot_bucket_store.sv -----
module hrot_bucket_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hrot_pkg::hrot_wr_t            wr,
  input  logic [hrot_pkg::ADDR_W-1:0]   rd_addr,
  output logic [hrot_pkg::BUCKET_W-1:0] rd_data
);
  import hrot_pkg::*;

  logic [BUCKET_W-1:0]     mem [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] valid_r;
  logic [BUCKET_W-1:0]     rd_data_r;

  // Per-entry valid bits stand in for the all-zero reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // One write port, one registered read port; never-written entries read zero
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/hourly_relay_on_time_tracker_unit.sv -----
// Hourly relay on-time tracker. Relay edges (mode 0) open and close on-intervals and
// periodic updates (mode 1) close the previous hour and clear the new one, each adding
// seconds into 24 hourly buckets capped at 3600. Every accepted beat returns one result
// beat: the on-seconds summed over the last window_hours buckets ending at the current
// hour, and whether an interval is open. Work runs through one shared adder/subtractor
// and a bucket store with one write and one read port, one beat at a time; the window
// sum reads one bucket per cycle, window_hours being capped at 24. The buckets read as
// zero straight after reset; no clearing pass is needed. The user writes window_hours
// through the cfg port only while the block is idle; the block does not enforce this.
module hourly_relay_on_time_tracker_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  hrot_pkg::hrot_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output hrot_pkg::hrot_out_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hrot_pkg::WIN_W-1:0] cfg_data
);
  import hrot_pkg::*;

`include "hourly_relay_on_time_tracker_unit_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ROLL_DUR,
    S_BADD_RD,
    S_BADD_WR,
    S_CLEAR,
    S_GAP,
    S_SUM_START,
    S_SUM,
    S_OUT
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  // Captured beat
  logic                mode_r, mode_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [HOUR_W-1:0]   hour_r, hour_nxt;
  logic [INTO_W-1:0]   into_r, into_nxt;
  logic                relay_r, relay_nxt;

  // Tracker state
  logic [TIME_W-1:0]   on_start_r, on_start_nxt;
  logic [HOUR_W-1:0]   tracked_r, tracked_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic [WIN_W-1:0]    window_r, window_nxt;

  // Working registers
  logic [TIME_W-1:0]   bnd_r, bnd_nxt;
  logic [TIME_W-1:0]   amount_r, amount_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [WIN_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;

  logic                out_valid_r, out_valid_nxt;
  hrot_out_t           out_data_r, out_data_nxt;

  // Shared unit and store hookup
  hrot_alu_op_t        alu_op;
  logic [TIME_W-1:0]   alu_a, alu_b;
  logic [TIME_W:0]     alu_res;
  hrot_wr_t            wr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [BUCKET_W-1:0] rd_data;
  logic [BUCKET_W-1:0] sat_total;
  logic [HOUR_W-1:0]   in_hour;

  hrot_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  hrot_bucket_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Hours past the last bucket fold onto it
  assign in_hour = (in_data.hour_of_day > LAST_HOUR) ? LAST_HOUR : in_data.hour_of_day;

  // Bucket plus amount, saturated at one hour (carry counts as overflow)
  assign sat_total = (alu_res > {(TIME_W + 1 - BUCKET_W)'(0), HOUR_CAP}) ?
                     HOUR_CAP : alu_res[BUCKET_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    mode_nxt      = mode_r;
    now_nxt       = now_r;
    hour_nxt      = hour_r;
    into_nxt      = into_r;
    relay_nxt     = relay_r;
    on_start_nxt  = on_start_r;
    tracked_nxt   = tracked_r;
    last_nxt      = last_r;
    window_nxt    = cfg_valid ? cfg_data : window_r;
    bnd_nxt       = bnd_r;
    amount_nxt    = amount_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    alu_op        = ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;
    wr            = '0;
    rd_addr       = addr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_data.mode;
          now_nxt   = in_data.now_seconds;
          hour_nxt  = in_hour;
          into_nxt  = in_data.seconds_into_hour;
          relay_nxt = in_data.relay_on;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        if (!mode_r) begin
          // relay edge: open an interval, or close it into this hour
          if (relay_r) begin
            on_start_nxt = now_r;
            state_nxt    = S_SUM_START;
          end else if (on_start_r != '0) begin
            alu_op       = ALU_SUB;
            alu_a        = now_r;
            alu_b        = on_start_r;
            amount_nxt   = alu_res[TIME_W-1:0];
            addr_nxt     = ADDR_W'(hour_r);
            on_start_nxt = '0;
            ret_nxt      = S_SUM_START;
            state_nxt    = S_BADD_RD;
          end else begin
            state_nxt = S_SUM_START;
          end
        end else if (hour_r != tracked_r) begin
          // hour rollover: work out the boundary if an interval is open
          if (on_start_r != '0 && tracked_r != NO_HOUR) begin
            alu_op    = ALU_SUB;
            alu_a     = now_r;
            alu_b     = {(TIME_W - INTO_W)'(0), into_r};
            bnd_nxt   = alu_res[TIME_W-1:0];
            state_nxt = S_ROLL_DUR;
          end else begin
            state_nxt = S_CLEAR;
          end
        end else begin
          state_nxt = S_GAP;
        end
      end

      S_ROLL_DUR: begin
        alu_op       = ALU_SUB;
        alu_a        = bnd_r;
        alu_b        = on_start_r;
        amount_nxt   = alu_res[TIME_W-1:0];
        addr_nxt     = ADDR_W'(tracked_r);
        on_start_nxt = bnd_r;
        ret_nxt      = S_CLEAR;
        state_nxt    = S_BADD_RD;
      end

      S_BADD_RD: begin
        state_nxt = S_BADD_WR;
      end

      S_BADD_WR: begin
        alu_op    = ALU_ADD;
        alu_a     = {(TIME_W - BUCKET_W)'(0), rd_data};
        alu_b     = amount_r;
        wr.en     = 1'b1;
        wr.addr   = addr_r;
        wr.data   = sat_total;
        state_nxt = ret_r;
      end

      S_CLEAR: begin
        wr.en       = 1'b1;
        wr.addr     = ADDR_W'(hour_r);
        wr.data     = '0;
        tracked_nxt = hour_r;
        state_nxt   = S_GAP;
      end

      S_GAP: begin
        // time since last update, only for short gaps while on
        last_nxt  = now_r;
        state_nxt = S_SUM_START;
        if (relay_r && on_start_r != '0) begin
          alu_op = ALU_SUB;
          alu_a  = now_r;
          alu_b  = last_r;
          if (last_r != '0 && alu_res[TIME_W-1:0] < GAP_LIMIT) begin
            amount_nxt = alu_res[TIME_W-1:0];
            addr_nxt   = ADDR_W'(hour_r);
            ret_nxt    = S_SUM_START;
            state_nxt  = S_BADD_RD;
          end
        end
      end

      S_SUM_START: begin
        cnt_nxt   = (window_r > MAX_WINDOW) ? MAX_WINDOW : window_r;
        idx_nxt   = ADDR_W'(hour_r);
        acc_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_SUM;
      end

      S_SUM: begin
        // issue one read a cycle, accumulate the one issued before
        rd_addr  = idx_r;
        pend_nxt = (cnt_r != '0);
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
          idx_nxt = (idx_r == '0) ? LAST_ADDR : idx_r - 1'b1;
        end
        if (pend_r) begin
          alu_op  = ALU_ADD;
          alu_a   = {(TIME_W - SUM_W)'(0), acc_r};
          alu_b   = {(TIME_W - BUCKET_W)'(0), rd_data};
          acc_nxt = alu_res[SUM_W-1:0];
        end
        // last read folded in this cycle
        if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.window_on_seconds = acc_r;
          out_data_nxt.tracked_on        = (on_start_r != '0);
          out_valid_nxt                  = 1'b1;
          state_nxt                      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_SUM_START;
      on_start_r  <= '0;
      tracked_r   <= NO_HOUR;
      last_r      <= '0;
      window_r    <= MAX_WINDOW;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      on_start_r  <= on_start_nxt;
      tracked_r   <= tracked_nxt;
      last_r      <= last_nxt;
      window_r    <= window_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r     <= mode_nxt;
    now_r      <= now_nxt;
    hour_r     <= hour_nxt;
    into_r     <= into_nxt;
    relay_r    <= relay_nxt;
    bnd_r      <= bnd_nxt;
    amount_r   <= amount_nxt;
    addr_r     <= addr_nxt;
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks
  `HROT_ASSERT(a_tracked_hour_ok, 1'b1, (tracked_r == NO_HOUR) || (tracked_r <= LAST_HOUR), "tracked hour outside bucket range")
  `HROT_ASSERT(a_bucket_capped, wr.en, wr.data <= HOUR_CAP, "bucket write above one hour")
  `HROT_ASSERT(a_sum_bound, state_r == S_SUM, acc_r <= SUM_W'(86400), "window sum above one day")
  `HROT_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_r == S_DISPATCH, "accepted beat not dispatched")

endmodule
